// File: rtl/core/mfhd_pkg.sv
package mfhd_pkg;

    // field widths
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned TYPE_W = 4;
    localparam int unsigned LEN_W  = 28;
    localparam int unsigned CNT_W  = 2;

    // value bits and continuation flag of one length byte
    localparam logic [BYTE_W-2:0] LEN_GROUP_MASK = 7'h7f;
    localparam int unsigned       CONT_BIT       = 7;

    // last length byte index (fourth byte)
    localparam logic [CNT_W-1:0] LAST_LEN_IDX = 2'd3;

    // byte kind codes as seen on the output
    typedef enum logic [1:0] {
        KIND_TYPE = 2'd0,
        KIND_LEN  = 2'd1,
        KIND_BODY = 2'd2
    } t_kind;

    // framing phase, one-hot
    typedef enum logic [2:0] {
        PH_TYPE = 3'b001,
        PH_LEN  = 3'b010,
        PH_BODY = 3'b100
    } t_phase;

    // one result beat
    typedef struct packed {
        logic [BYTE_W-1:0] byte_out;
        t_kind             byte_kind;
        logic [TYPE_W-1:0] packet_type;
        logic [LEN_W-1:0]  remaining_length;
        logic              is_last;
        logic              length_error;
    } t_result;

endpackage

// File: rtl/core/mqtt_fixed_header_deframer_top.sv
// channel  | direction | handshake                  | payload
// ---------+-----------+----------------------------+----------------------------------------
// in       | input     | i_in_valid / o_in_stall    | i_data_byte
// out      | output    | o_out_valid / i_out_stall  | o_byte_out, o_byte_kind, o_packet_type,
//          |           |                            | o_remaining_length, o_is_last,
//          |           |                            | o_length_error
//
// one beat per cycle unless stalled; bytes pass the input register, then the result register
// the byte decode (length group merge, body countdown) sits between the input
// register and the result register, and the framing state advances as a beat moves
// synchronous active-low reset empties both registers and returns to the type byte
// a stall on the out channel reaches o_in_stall in the same cycle once both
// registers hold a beat
module mqtt_fixed_header_deframer_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic [mfhd_pkg::BYTE_W-1:0] i_data_byte,
    output logic                        o_in_stall,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [mfhd_pkg::BYTE_W-1:0] o_byte_out,
    output logic [1:0]                  o_byte_kind,
    output logic [mfhd_pkg::TYPE_W-1:0] o_packet_type,
    output logic [mfhd_pkg::LEN_W-1:0]  o_remaining_length,
    output logic                        o_is_last,
    output logic                        o_length_error
);

    logic                        stage_valid;
    logic [mfhd_pkg::BYTE_W-1:0] stage_data;
    logic                        advance;
    logic                        fire;
    mfhd_pkg::t_result           step_result;
    mfhd_pkg::t_result           out_result;

    // input register
    mfhd_in_stage u_in (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_data_byte (i_data_byte),
        .o_in_stall  (o_in_stall),
        .i_advance   (advance),
        .o_valid     (stage_valid),
        .o_data      (stage_data)
    );

    // a beat moves into the result register
    assign fire = stage_valid && advance;

    mfhd_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_data   (stage_data),
        .o_result (step_result)
    );

    // result register
    mfhd_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (stage_valid),
        .i_result    (step_result),
        .o_advance   (advance),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (out_result)
    );

    assign o_byte_out         = out_result.byte_out;
    assign o_byte_kind        = out_result.byte_kind;
    assign o_packet_type      = out_result.packet_type;
    assign o_remaining_length = out_result.remaining_length;
    assign o_is_last          = out_result.is_last;
    assign o_length_error     = out_result.length_error;

`ifndef SYNTH
    // only a length byte can carry the overlong flag
    a_err_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_length_error |-> o_byte_kind == mfhd_pkg::KIND_LEN)
        else $error("length error on a non-length byte");

    // a type byte never completes a packet
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_last |-> o_byte_kind != mfhd_pkg::KIND_TYPE)
        else $error("packet ended on its type byte");

    // type byte starts a fresh length
    a_type_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_byte_kind == mfhd_pkg::KIND_TYPE |-> o_remaining_length == '0)
        else $error("length not cleared on type byte");
`endif

endmodule

// File: rtl/core/mfhd_in_stage.sv
module mfhd_in_stage (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic [mfhd_pkg::BYTE_W-1:0] i_data_byte,
    output logic                       o_in_stall,
    input  logic                       i_advance,
    output logic                       o_valid,
    output logic [mfhd_pkg::BYTE_W-1:0] o_data
);

    logic                        r_valid;
    logic [mfhd_pkg::BYTE_W-1:0] r_data;

    // hold the beat while the step cannot move it on
    assign o_in_stall = r_valid && !i_advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_data <= i_data_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// File: rtl/core/mfhd_step.sv
module mfhd_step (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_fire,
    input  logic [mfhd_pkg::BYTE_W-1:0] i_data,
    output mfhd_pkg::t_result           o_result
);

    mfhd_pkg::t_phase                   r_phase, n_phase;
    logic [mfhd_pkg::TYPE_W-1:0]        r_type, n_type;
    logic [mfhd_pkg::LEN_W-1:0]         r_accum, n_accum;
    logic [mfhd_pkg::CNT_W-1:0]         r_len_cnt, n_len_cnt;
    logic [mfhd_pkg::LEN_W-1:0]         r_body_left, n_body_left;

    logic [mfhd_pkg::LEN_W-1:0]         group_shifted;
    logic [mfhd_pkg::LEN_W-1:0]         accum_or;
    logic [mfhd_pkg::LEN_W-1:0]         body_dec;
    logic [mfhd_pkg::BYTE_W-2:0]        group;
    logic                               cont;

    assign group    = i_data[mfhd_pkg::BYTE_W-2:0] & mfhd_pkg::LEN_GROUP_MASK;
    assign cont     = i_data[mfhd_pkg::CONT_BIT];
    assign body_dec = r_body_left - mfhd_pkg::LEN_W'(1);

    // place the 7-bit group by length byte index
    always_comb begin
        unique case (r_len_cnt)
            2'd0:    group_shifted = {21'd0, group};
            2'd1:    group_shifted = {14'd0, group, 7'd0};
            2'd2:    group_shifted = {7'd0, group, 14'd0};
            default: group_shifted = {group, 21'd0};
        endcase
    end

    assign accum_or = r_accum | group_shifted;

    // next state and result for one beat
    always_comb begin
        n_phase     = r_phase;
        n_type      = r_type;
        n_accum     = r_accum;
        n_len_cnt   = r_len_cnt;
        n_body_left = r_body_left;

        o_result.byte_out     = i_data;
        o_result.byte_kind    = mfhd_pkg::KIND_TYPE;
        o_result.is_last      = 1'b0;
        o_result.length_error = 1'b0;

        unique case (r_phase)
            mfhd_pkg::PH_LEN: begin
                o_result.byte_kind = mfhd_pkg::KIND_LEN;
                n_accum            = accum_or;
                if (!cont || r_len_cnt == mfhd_pkg::LAST_LEN_IDX) begin
                    o_result.length_error = cont;
                    n_len_cnt             = '0;
                    if (accum_or == '0) begin
                        o_result.is_last = 1'b1;
                        n_phase          = mfhd_pkg::PH_TYPE;
                    end else begin
                        n_body_left = accum_or;
                        n_phase     = mfhd_pkg::PH_BODY;
                    end
                end else begin
                    n_len_cnt = r_len_cnt + mfhd_pkg::CNT_W'(1);
                end
            end
            mfhd_pkg::PH_BODY: begin
                o_result.byte_kind = mfhd_pkg::KIND_BODY;
                n_body_left        = body_dec;
                if (body_dec == '0) begin
                    o_result.is_last = 1'b1;
                    n_phase          = mfhd_pkg::PH_TYPE;
                end
            end
            default: begin
                // type/flags byte opens a packet
                n_type      = i_data[mfhd_pkg::BYTE_W-1 -: mfhd_pkg::TYPE_W];
                n_accum     = '0;
                n_len_cnt   = '0;
                n_body_left = '0;
                n_phase     = mfhd_pkg::PH_LEN;
            end
        endcase

        o_result.packet_type      = n_type;
        o_result.remaining_length = n_accum;
    end

    // framing state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= mfhd_pkg::PH_TYPE;
            r_type      <= '0;
            r_accum     <= '0;
            r_len_cnt   <= '0;
            r_body_left <= '0;
        end else if (i_fire) begin
            r_phase     <= n_phase;
            r_type      <= n_type;
            r_accum     <= n_accum;
            r_len_cnt   <= n_len_cnt;
            r_body_left <= n_body_left;
        end
    end

`ifndef SYNTH
    // body phase always has bytes left to count
    a_body_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == mfhd_pkg::PH_BODY |-> r_body_left != '0)
        else $error("body phase with zero bytes left");

    // length byte counter only runs inside the length bytes
    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != mfhd_pkg::PH_LEN |-> r_len_cnt == '0)
        else $error("length byte count not cleared");

    // last body byte returns to the type byte
    a_body_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && r_phase == mfhd_pkg::PH_BODY && r_body_left == mfhd_pkg::LEN_W'(1)
        |=> r_phase == mfhd_pkg::PH_TYPE)
        else $error("packet did not end after last body byte");
`endif

endmodule

// File: rtl/core/mfhd_out_stage.sv
module mfhd_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  mfhd_pkg::t_result i_result,
    output logic              o_advance,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output mfhd_pkg::t_result o_result
);

    logic              r_valid;
    mfhd_pkg::t_result r_result;

    // register is free when empty or being drained
    assign o_advance = !r_valid || !i_out_stall;

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_valid) begin
            r_result <= i_result;
        end
    end

    assign o_out_valid = r_valid;
    assign o_result    = r_result;

endmodule
